@@ rtl/core/mm_pkg.sv @@
// shared types and constants for the matrix multiply core
// no dependencies; imported by mm_ctrl, mm_dpath and the top level
`timescale 1ns / 1ps

package mm_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 3;
  localparam int OP_W          = 2;
  localparam int CFG_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS    = 2'd0,
    CFG_A_COLS    = 2'd1,
    CFG_B_COLS    = 2'd2,
    CFG_TRANSPOSE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] a_rows;
    logic [CFG_W-1:0] a_cols;
    logic [CFG_W-1:0] b_cols;
    logic             transpose;
  } mm_cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic             tr;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mm_cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } mm_status_t;

endpackage

@@ rtl/core/mm_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mm_ctrl.sv @@
// controller: input handshake, element sequencing and inner-loop issue
// depends on mm_pkg
`timescale 1ns / 1ps

module mm_ctrl import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OP_W-1:0]  op_i,
  input  mm_cfg_t          cfg_i,
  input  mm_status_t       status_i,
  output mm_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  localparam logic [CFG_W-1:0] DimMax = CFG_W'(MAX_DIM);

  state_e           state_q;
  logic [IDX_W-1:0] i_q, j_q, k_q;
  logic [IDX_W-1:0] ar_m1, ac_m1, bc_m1, orows_m1, inner_m1;
  logic             accept, last_elem;

  // clamp a dimension register to 1..MAX_DIM, returned minus one
  function automatic logic [IDX_W-1:0] dim_m1(input logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] c;
    if (d == '0) begin
      c = CFG_W'(1);
    end else if (d > DimMax) begin
      c = DimMax;
    end else begin
      c = d;
    end
    return IDX_W'(c - CFG_W'(1));
  endfunction

  assign ar_m1    = dim_m1(cfg_i.a_rows);
  assign ac_m1    = dim_m1(cfg_i.a_cols);
  assign bc_m1    = dim_m1(cfg_i.b_cols);
  assign orows_m1 = cfg_i.transpose ? ac_m1 : ar_m1;
  assign inner_m1 = cfg_i.transpose ? ar_m1 : ac_m1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_elem  = (i_q == orows_m1) && (j_q == bc_m1);

  always_comb begin
    cmd_o.wr_a      = accept && (op_i == OP_WRITE_A);
    cmd_o.wr_b      = accept && (op_i == OP_WRITE_B);
    cmd_o.rd        = (state_q == ST_ISSUE);
    cmd_o.first     = (k_q == '0);
    cmd_o.last_k    = (k_q == inner_m1);
    cmd_o.last_elem = last_elem;
    cmd_o.tr        = cfg_i.transpose;
    cmd_o.i         = i_q;
    cmd_o.j         = j_q;
    cmd_o.k         = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (op_i == OP_COMPUTE)) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_START;
          end
        end
        // one element in flight at a time; wait for the output word to clear
        ST_START: begin
          if (!status_i.out_busy) begin
            k_q     <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_q == inner_m1) begin
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (status_i.done) begin
            if (last_elem) begin
              state_q <= ST_IDLE;
            end else begin
              if (j_q == bc_m1) begin
                j_q <= '0;
                i_q <= i_q + IDX_W'(1);
              end else begin
                j_q <= j_q + IDX_W'(1);
              end
              state_q <= ST_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/mm_dpath.sv @@
// datapath: operand stores, multiply, wide accumulate, round and saturate
// depends on mm_pkg and mm_ram
`timescale 1ns / 1ps

module mm_dpath import mm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mm_cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  output mm_status_t               status_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     saturated_o,
  output logic                     last_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int HI_W   = ACC_W - DATA_W + 1;
  localparam logic [IDX_W:0] DimL = (IDX_W + 1)'(MAX_DIM);
  localparam logic signed [ACC_W-1:0] RoundC = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [DATA_W-1:0] SatPos = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] SatNeg = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
  } tag_t;

  logic              wr_ok, we_a, we_b;
  logic [AW-1:0]     waddr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_rd, b_rd;

  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  tag_t                     s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, prod_ext;
  logic signed [ACC_W-1:0]  rnd, shifted;
  logic [HI_W-1:0]          hi_bits;
  logic                     ovf, done;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic [DATA_W-1:0]        out_value_q;
  logic                     out_sat_q, out_last_q;

  // writes outside the MAX_DIM x MAX_DIM store are dropped
  assign wr_ok = ({1'b0, row_i} < DimL) && ({1'b0, col_i} < DimL);
  assign we_a  = cmd_i.wr_a && wr_ok;
  assign we_b  = cmd_i.wr_b && wr_ok;
  assign waddr = AW'(int'(row_i) * MAX_DIM + int'(col_i));

  assign a_raddr = cmd_i.tr ? AW'(int'(cmd_i.k) * MAX_DIM + int'(cmd_i.i))
                            : AW'(int'(cmd_i.i) * MAX_DIM + int'(cmd_i.k));
  assign b_raddr = AW'(int'(cmd_i.k) * MAX_DIM + int'(cmd_i.j));

  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(a_raddr),
    .rdata_o(a_rd)
  );

  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .raddr_i(b_raddr),
    .rdata_o(b_rd)
  );

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = s2_tag_q.first ? prod_ext : acc_q + prod_ext;

  // round half up, then check the upper bits for 32-bit range
  assign rnd     = acc_q + RoundC;
  assign shifted = rnd >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DATA_W-1];
  assign ovf     = !((&hi_bits) || (~|hi_bits));
  assign done    = s3_valid_q && s3_tag_q.last_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.rd;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q.first     <= cmd_i.first;
    s1_tag_q.last_k    <= cmd_i.last_k;
    s1_tag_q.last_elem <= cmd_i.last_elem;
    s1_tag_q.i         <= cmd_i.i;
    s1_tag_q.j         <= cmd_i.j;
    s2_tag_q           <= s1_tag_q;
    prod_q             <= signed'(a_rd) * signed'(b_rd);
    s3_tag_q           <= s2_tag_q;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (done) begin
      out_row_q   <= s3_tag_q.i;
      out_col_q   <= s3_tag_q.j;
      out_value_q <= ovf ? (rnd[ACC_W-1] ? SatNeg : SatPos) : shifted[DATA_W-1:0];
      out_sat_q   <= ovf;
      out_last_q  <= s3_tag_q.last_elem;
    end
  end

  assign status_o.done     = done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

endmodule

@@ rtl/core/matrix_multiply_core.sv @@
// fixed-point matrix multiply core top: config registers, ctrl, datapath
// depends on mm_pkg, mm_ctrl, mm_dpath
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i/in_ready_o): op 0 loads row_i/col_i/value_i
//   into store A, op 1 into store B, op 2 starts a product, op 3 is ignored.
//   Loads are written while the core is idle and may follow back to back.
//   A compute word returns rows x cols result words on the output channel
//   (out_valid_o/out_ready_i) in row-major order, last_o on the final one.
//   Each element passes a start state, one store read per inner step, then
//   the read, multiply and accumulate stages before the rounded word lands
//   in the output register. Input is not taken again until the product's
//   last element has completed.
//   Only one element is in flight; a stalled receiver holds the next element
//   at its start cycle, and a new input word is taken while the final result
//   still waits in the output register.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; write it only
//   while no product is pending.
//   Reset sets the dimensions to 1 and normal mode; the stores are not
//   cleared and must be loaded before use.

module matrix_multiply_core import mm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     saturated_o,
  output logic                     last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  mm_cfg_t    cfg_q;
  mm_cmd_t    cmd;
  mm_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows    <= CFG_W'(1);
      cfg_q.a_cols    <= CFG_W'(1);
      cfg_q.b_cols    <= CFG_W'(1);
      cfg_q.transpose <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_A_ROWS:    cfg_q.a_rows    <= cfg_data_i;
        CFG_A_COLS:    cfg_q.a_cols    <= cfg_data_i;
        CFG_B_COLS:    cfg_q.b_cols    <= cfg_data_i;
        CFG_TRANSPOSE: cfg_q.transpose <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .cfg_i     (cfg_q),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mm_dpath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .out_value_o(out_value_o),
    .saturated_o(saturated_o),
    .last_o     (last_o)
  );

`ifndef NO_ASSERTIONS
  // a finished element never lands on an output word still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !status.out_busy)
    else $error("result overwrote a pending output word");

  // store reads only start once the output register has drained
  a_issue_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |-> !out_valid_o)
    else $error("inner loop issued while output word pending");

  // elements complete only while a product is running
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !in_ready_o)
    else $error("element completed while input side idle");
`endif

endmodule
